FILE: hw/rtl/spt_pkg.sv
// Package for the stage profiler table: widths, register indexes, payload
// structs, sequencer states and divider handshake types.
// No dependencies.
`default_nettype none

package spt_pkg;

  localparam int TABLE_ENTRIES = 24;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W    = 32;
  localparam int TICK_W   = 64;
  localparam int SAMPLE_W = 16;
  localparam int WIN_W    = 40;
  localparam int TPU_W    = 10;
  localparam int DEN_W    = SAMPLE_W + TPU_W;

  // divider: quotient bits retired per cycle
  localparam int DIV_STEPS = 2;
  localparam int DIV_CYC   = TICK_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  localparam int CFG_W     = WIN_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TPU    = 2'd2;

  localparam logic [SAMPLE_W-1:0] PERIOD_RESET = 16'd600;
  localparam logic [WIN_W-1:0]    WINDOW_RESET = 40'd2681118560;
  localparam logic [TPU_W-1:0]    TPU_RESET    = 10'd268;

  typedef struct packed {
    logic [KEY_W-1:0]  stage_key;
    logic [TICK_W-1:0] start_ticks;
    logic [TICK_W-1:0] now_ticks;
  } spt_item_t;

  typedef struct packed {
    logic                report_valid;
    logic [KEY_W-1:0]    report_stage;
    logic [TICK_W-1:0]   mean_us;
    logic [TICK_W-1:0]   worst_us;
    logic [SAMPLE_W-1:0] report_samples;
    logic                table_full_drop;
  } spt_result_t;

  typedef struct packed {
    logic              go;
    logic [TICK_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } spt_div_req_t;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] quotient;
  } spt_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_CHECK,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_WORST_GO,
    ST_WORST_WAIT,
    ST_EMIT
  } spt_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stage_profiler_table.sv
// Stage profiler table: per-key timing statistics with periodic reports.
// Depends on spt_pkg and spt_div.
//
//   port group                   dir  handshake
//   start, item                  in   taken when start && !busy
//   done, result                 out  one-cycle strobe, no back-pressure
//   cfg_we, cfg_index, cfg_data  in   write when cfg_we, no wait
//
// An accepted item runs a linear key search over the slots in use, then an
// update of its slot and a report check; a report adds two passes through the
// shared divider, mean then worst. A new key on a full table goes straight to
// the result word. busy stays high until the result cycle ends. Reset is
// synchronous and empties the table.
`default_nettype none

module stage_profiler_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire spt_pkg::spt_item_t            item,
  output logic                               done,
  output spt_pkg::spt_result_t               result,
  input  wire logic                          cfg_we,
  input  wire logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [spt_pkg::CFG_W-1:0]     cfg_data
);
  import spt_pkg::*;

  spt_state_t state, state_next;

  logic [SAMPLE_W-1:0] period;
  logic [WIN_W-1:0]    window;
  logic [TPU_W-1:0]    tpu;

  logic [KEY_W-1:0]    key_tab   [TABLE_ENTRIES];
  logic [TICK_W-1:0]   tot_tab   [TABLE_ENTRIES];
  logic [TICK_W-1:0]   worst_tab [TABLE_ENTRIES];
  logic [TICK_W-1:0]   ws_tab    [TABLE_ENTRIES];
  logic [SAMPLE_W-1:0] cnt_tab   [TABLE_ENTRIES];
  logic [FILL_W-1:0]   fill;

  logic [KEY_W-1:0]    cur_key;
  logic [TICK_W-1:0]   cur_now;
  logic [TICK_W-1:0]   elapsed;
  logic [FILL_W-1:0]   idx;
  logic                fresh;

  logic [TICK_W-1:0]   snap_total;
  logic [TICK_W-1:0]   snap_worst;
  logic [SAMPLE_W-1:0] snap_cnt;
  logic [DEN_W-1:0]    den;
  logic [TICK_W-1:0]   mean_val;
  spt_result_t         res;

  spt_div_req_t        div_req;
  spt_div_rsp_t        div_rsp;

  logic [IDX_W-1:0]    slot;
  logic                at_end;
  logic                is_full;
  logic                key_hit;
  logic [TICK_W-1:0]   age;
  logic                report;

  assign slot    = idx[IDX_W-1:0];
  assign at_end  = (idx == fill);
  assign is_full = (fill == FILL_W'(TABLE_ENTRIES));
  assign key_hit = !at_end && (key_tab[slot] == cur_key);
  assign age     = cur_now - ws_tab[slot];
  assign report  = !((cnt_tab[slot] < period) &&
                     (age < {{(TICK_W-WIN_W){1'b0}}, window}));

  spt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (start) state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (at_end) state_next = is_full ? ST_EMIT : ST_UPDATE;
        else if (key_hit) state_next = ST_UPDATE;
      end
      ST_UPDATE:     state_next = ST_CHECK;
      ST_CHECK:      state_next = report ? ST_MEAN_GO : ST_EMIT;
      ST_MEAN_GO:    state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT:  if (div_rsp.done) state_next = ST_WORST_GO;
      ST_WORST_GO:   state_next = ST_WORST_WAIT;
      ST_WORST_WAIT: if (div_rsp.done) state_next = ST_EMIT;
      ST_EMIT:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs and divider requests
  always_comb begin
    busy             = 1'b1;
    done             = 1'b0;
    div_req.go       = 1'b0;
    div_req.dividend = snap_total;
    div_req.divisor  = den;
    case (state)
      ST_IDLE:     busy = 1'b0;
      ST_MEAN_GO:  div_req.go = 1'b1;
      ST_WORST_GO: begin
        div_req.go       = 1'b1;
        div_req.dividend = snap_worst;
        div_req.divisor  = DEN_W'(tpu);
      end
      ST_EMIT:     done = 1'b1;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      period <= PERIOD_RESET;
      window <= WINDOW_RESET;
      tpu    <= TPU_RESET;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE && fresh) fill <= fill + 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD: period <= cfg_data[SAMPLE_W-1:0];
          REG_WINDOW: window <= cfg_data[WIN_W-1:0];
          REG_TPU:    tpu    <= cfg_data[TPU_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_key <= item.stage_key;
        cur_now <= item.now_ticks;
        elapsed <= item.now_ticks - item.start_ticks;
        idx     <= '0;
      end
      ST_SEARCH: begin
        fresh <= at_end;
        if (at_end && is_full) begin
          res <= '{report_valid: 1'b0, report_stage: '0, mean_us: '0, worst_us: '0,
                   report_samples: '0, table_full_drop: 1'b1};
        end else if (!at_end && !key_hit) begin
          idx <= idx + 1'b1;
        end
      end
      ST_UPDATE: begin
        if (fresh) begin
          key_tab[slot]   <= cur_key;
          ws_tab[slot]    <= cur_now;
          tot_tab[slot]   <= elapsed;
          worst_tab[slot] <= elapsed;
          cnt_tab[slot]   <= SAMPLE_W'(1);
        end else begin
          tot_tab[slot] <= tot_tab[slot] + elapsed;
          if (cnt_tab[slot] != '1) cnt_tab[slot] <= cnt_tab[slot] + 1'b1;
          if (elapsed > worst_tab[slot]) worst_tab[slot] <= elapsed;
        end
      end
      ST_CHECK: begin
        res <= '0;
        if (report) begin
          snap_total      <= tot_tab[slot];
          snap_worst      <= worst_tab[slot];
          snap_cnt        <= cnt_tab[slot];
          den             <= DEN_W'(cnt_tab[slot]) * DEN_W'(tpu);
          // close the window and restart it at this sample
          tot_tab[slot]   <= '0;
          worst_tab[slot] <= '0;
          cnt_tab[slot]   <= '0;
          ws_tab[slot]    <= cur_now;
        end
      end
      ST_MEAN_WAIT: begin
        if (div_rsp.done) mean_val <= div_rsp.quotient;
      end
      ST_WORST_WAIT: begin
        if (div_rsp.done) begin
          res.report_valid    <= 1'b1;
          res.report_stage    <= cur_key;
          res.mean_us         <= mean_val;
          res.worst_us        <= div_rsp.quotient;
          res.report_samples  <= snap_cnt;
          res.table_full_drop <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign result = res;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_ENTRIES))
    else $error("key table fill count beyond table size");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result word");

  a_drop_excl: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full_drop) |-> !result.report_valid)
    else $error("dropped sample carries a report");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/spt_div.sv
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on spt_pkg. A zero divisor yields an all-ones quotient.
`default_nettype none

module spt_div (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire spt_pkg::spt_div_req_t req,
  output spt_pkg::spt_div_rsp_t      rsp
);
  import spt_pkg::*;

  logic                 active;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TICK_W-1:0]    quo;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;

  logic [TICK_W-1:0]    quo_next;
  logic [DEN_W-1:0]     rem_next;
  logic [DEN_W:0]       shifted;

  always_comb begin
    quo_next = quo;
    rem_next = rem;
    shifted  = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      shifted  = {rem_next, quo_next[TICK_W-1]};
      quo_next = {quo_next[TICK_W-2:0], 1'b0};
      if (shifted >= {1'b0, den}) begin
        shifted     = shifted - {1'b0, den};
        quo_next[0] = 1'b1;
      end
      rem_next = shifted[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      quo <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (active) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

FILE: verif/stage_profiler_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for stage_profiler_table: directed table probes,
// then randomized timing samples checked against a per-stage statistics model.
// Depends on spt_pkg and the stage_profiler_table RTL.

module stage_profiler_table_tb;
  import spt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SAMPLES_PER_CHUNK = 200;
  localparam int CHUNKS = 6;
  localparam spt_result_t NO_REPORT = '0;
  localparam spt_result_t FULL_DROP = spt_result_t'(1);

  typedef struct {
    bit              reprogram;
    longint unsigned period_d;
    longint unsigned window_d;
    longint unsigned tpu_d;
    spt_item_t       w;
    bit              pinned;
    spt_result_t     want;
  } probe_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  spt_item_t            item = '0;
  logic                 done;
  spt_result_t          result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // typed-in expectation travels with the word it belongs to
  logic        pin_on = 1'b0;
  spt_result_t pin_word = '0;

  // model of the block's table and registers
  logic [KEY_W-1:0]    stage_keys [TABLE_ENTRIES];
  int                  keys_held;
  logic [TICK_W-1:0]   tick_sum   [TABLE_ENTRIES];
  logic [TICK_W-1:0]   tick_worst [TABLE_ENTRIES];
  logic [TICK_W-1:0]   win_origin [TABLE_ENTRIES];
  logic [SAMPLE_W-1:0] hits       [TABLE_ENTRIES];
  logic [SAMPLE_W-1:0] period_q;
  logic [WIN_W-1:0]    window_q;
  logic [TPU_W-1:0]    tpu_q;

  spt_result_t       expected_words[$];
  probe_row_t        probe_rows[$];
  logic [TICK_W-1:0] tick_now = 64'hFFFF_FFFF_FFF0_0000;
  int mismatches = 0;
  int samples_taken = 0;
  int reports_seen = 0;
  int drops_seen = 0;
  int settings_used = 0;

  stage_profiler_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [TICK_W-1:0] ticks_to_us(logic [TICK_W-1:0] t);
    if (tpu_q == '0) return '1;
    return t / {{(TICK_W-TPU_W){1'b0}}, tpu_q};
  endfunction

  function automatic spt_result_t profile_sample(spt_item_t w);
    spt_result_t       r;
    logic [TICK_W-1:0] lapse;
    int                slot;
    int                i;
    r = NO_REPORT;
    lapse = w.now_ticks - w.start_ticks;
    slot = keys_held;
    for (i = 0; i < keys_held; i++)
      if (slot == keys_held && stage_keys[i] == w.stage_key) slot = i;
    if (slot == keys_held) begin
      if (keys_held == TABLE_ENTRIES) begin
        r.table_full_drop = 1'b1;
        return r;
      end
      stage_keys[slot] = w.stage_key;
      win_origin[slot] = w.now_ticks;
      keys_held++;
    end
    tick_sum[slot] = tick_sum[slot] + lapse;
    if (hits[slot] != '1) hits[slot] = hits[slot] + 1'b1;
    if (lapse > tick_worst[slot]) tick_worst[slot] = lapse;
    if (hits[slot] < period_q &&
        (w.now_ticks - win_origin[slot]) < {{(TICK_W-WIN_W){1'b0}}, window_q})
      return r;
    r.report_valid = 1'b1;
    r.report_stage = w.stage_key;
    r.mean_us = ticks_to_us(tick_sum[slot] / {{(TICK_W-SAMPLE_W){1'b0}}, hits[slot]});
    r.worst_us = ticks_to_us(tick_worst[slot]);
    r.report_samples = hits[slot];
    tick_sum[slot] = '0;
    tick_worst[slot] = '0;
    hits[slot] = '0;
    win_origin[slot] = w.now_ticks;
    return r;
  endfunction

  // check the word on the result port, then track writes and accepted samples
  always @(posedge clk) begin : score_words
    spt_result_t want;
    spt_result_t guess;
    int i;
    if (rst) begin
      keys_held = 0;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        stage_keys[i] = '0;
        tick_sum[i] = '0;
        tick_worst[i] = '0;
        win_origin[i] = '0;
        hits[i] = '0;
      end
      period_q = PERIOD_RESET;
      window_q = WINDOW_RESET;
      tpu_q = TPU_RESET;
    end else begin
      if (done === 1'b1) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (result.report_valid !== want.report_valid) begin
            $error("report_valid: expected %0h, got %0h", want.report_valid, result.report_valid);
            mismatches++;
          end
          if (result.report_stage !== want.report_stage) begin
            $error("report_stage: expected %0h, got %0h", want.report_stage, result.report_stage);
            mismatches++;
          end
          if (result.mean_us !== want.mean_us) begin
            $error("mean_us: expected %0h, got %0h", want.mean_us, result.mean_us);
            mismatches++;
          end
          if (result.worst_us !== want.worst_us) begin
            $error("worst_us: expected %0h, got %0h", want.worst_us, result.worst_us);
            mismatches++;
          end
          if (result.report_samples !== want.report_samples) begin
            $error("report_samples: expected %0h, got %0h",
                   want.report_samples, result.report_samples);
            mismatches++;
          end
          if (result.table_full_drop !== want.table_full_drop) begin
            $error("table_full_drop: expected %0h, got %0h",
                   want.table_full_drop, result.table_full_drop);
            mismatches++;
          end
        end
      end else if (done !== 1'b0) begin
        $error("done: expected 0 or 1, got %b", done);
        mismatches++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD: period_q = cfg_data[SAMPLE_W-1:0];
          REG_WINDOW: window_q = cfg_data[WIN_W-1:0];
          REG_TPU:    tpu_q = cfg_data[TPU_W-1:0];
          default: ;
        endcase
      end
      if (start && busy === 1'b0) begin
        guess = profile_sample(item);
        expected_words.push_back(pin_on ? pin_word : guess);
        samples_taken++;
        if (guess.report_valid) reports_seen++;
        if (guess.table_full_drop) drops_seen++;
      end
    end
  end

  function automatic void add_probe(bit reprogram, longint unsigned period_d,
                                    longint unsigned window_d, longint unsigned tpu_d,
                                    spt_item_t w, bit pinned, spt_result_t want);
    probe_row_t row;
    row.reprogram = reprogram;
    row.period_d = period_d;
    row.window_d = window_d;
    row.tpu_d = tpu_d;
    row.w = w;
    row.pinned = pinned;
    row.want = want;
    probe_rows.push_back(row);
  endfunction

  function automatic spt_item_t draw_sample();
    spt_item_t         w;
    logic [TICK_W-1:0] lapse;
    if ($urandom_range(0, 99) < 8 || keys_held == 0) w.stage_key = $urandom;
    else w.stage_key = stage_keys[$urandom_range(0, keys_held - 1)];
    if ($urandom_range(0, 9) == 0) begin
      w.start_ticks = {$urandom, $urandom};
      w.now_ticks = {$urandom, $urandom};
    end else begin
      // advance a shared tick counter; it wraps early in the run
      tick_now = tick_now + 64'($urandom_range(0, 3000));
      if ($urandom_range(0, 99) < 85) lapse = 64'($urandom_range(0, 2000));
      else lapse = {$urandom, $urandom} >> $urandom_range(0, 63);
      w.start_ticks = tick_now - lapse;
      w.now_ticks = tick_now;
    end
    return w;
  endfunction

  task automatic send_word(spt_item_t w, bit pinned, spt_result_t want);
    item <= w;
    start <= 1'b1;
    pin_on <= pinned;
    pin_word <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic maybe_idle(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 110)) @(posedge clk);
    end
  endtask

  // hold off until every expected word is back and the block is idle
  task automatic settle(int tail);
    start <= 1'b0;
    do @(negedge clk); while (expected_words.size() != 0 || busy !== 1'b0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic program_regs(longint unsigned period_d, longint unsigned window_d,
                              longint unsigned tpu_d);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_we <= 1'b1;
    cfg_index <= REG_PERIOD;
    cfg_data <= period_d[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_WINDOW;
    cfg_data <= window_d[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_TPU;
    cfg_data <= tpu_d[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= junk[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int idle_pct;
    int k;
    logic [KEY_W-1:0] fill_key;

    // reset registers: age just under, then at, the window length
    add_probe(1'b0, 0, 0, 0, {32'h0000_0000, 64'h0, 64'h0}, 1'b1, NO_REPORT);
    add_probe(1'b0, 0, 0, 0, {32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
              1'b1, NO_REPORT);
    add_probe(1'b0, 0, 0, 0, {32'hFFFF_FFFF, 64'h0, 64'd2681118559}, 1'b1, NO_REPORT);
    add_probe(1'b0, 0, 0, 0, {32'hFFFF_FFFF, 64'h0, 64'd2681118560}, 1'b0, NO_REPORT);
    add_probe(1'b0, 0, 0, 0, {32'h0000_0000, 64'h8000_0000_0000_0000,
              64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, NO_REPORT);
    // one sample per report, unit divisor
    add_probe(1'b1, 64'd1, 64'hFF_FFFF_FFFF, 64'd1,
              {32'h1234_5678, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
              {1'b1, 32'h1234_5678, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               16'd1, 1'b0});
    add_probe(1'b0, 0, 0, 0, {32'h0000_0000, 64'd5, 64'd5}, 1'b1,
              {1'b1, 32'h0, 64'h0, 64'h0, 16'd1, 1'b0});
    // fill the remaining slots, then overflow the table
    for (k = 3; k < TABLE_ENTRIES; k++) begin
      fill_key = 32'h5A5A_0000 | 32'(k);
      add_probe(1'b0, 0, 0, 0, {fill_key, 64'(k), 64'(k * 7)}, 1'b1,
                {1'b1, fill_key, 64'(k * 6), 64'(k * 6), 16'd1, 1'b0});
    end
    add_probe(1'b0, 0, 0, 0, {32'h7FFF_FFFF, 64'd100, 64'd200}, 1'b1, FULL_DROP);
    // period, window and divisor all cut to zero
    add_probe(1'b1, 64'hFF_FFFF_0000, 64'd0, 64'hFF_FFFF_FC00,
              {32'hFFFF_FFFF, 64'd10, 64'd3}, 1'b1,
              {1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               16'd1, 1'b0});
    add_probe(1'b0, 0, 0, 0, {32'h7FFF_FFFF, 64'h0, 64'h0}, 1'b1, FULL_DROP);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probe_rows[n]) begin
      if (probe_rows[n].reprogram) begin
        settle(4);
        program_regs(probe_rows[n].period_d, probe_rows[n].window_d, probe_rows[n].tpu_d);
      end
      send_word(probe_rows[n].w, probe_rows[n].pinned, probe_rows[n].want);
    end

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      settle(4);
      case (chunk)
        0: program_regs(64'($urandom_range(1, 6)), 64'($urandom_range(50000, 500000)),
                        64'($urandom_range(1, 1023)));
        1: program_regs(64'hAB_CDEF_FFFF, 64'($urandom_range(30000, 200000)), 64'd1023);
        2: program_regs(64'd1, 64'd1, 64'd1);
        3: program_regs(64'hFF_FFFF_0000, 64'd0, 64'hFF_FFFF_FC00);
        4: program_regs(64'($urandom_range(2, 10)), 64'hFF_FFFF_FFFF,
                        64'($urandom_range(1, 50)));
        default: program_regs(64'($urandom_range(3, 20)), {$urandom, $urandom}, 64'd268);
      endcase
      idle_pct = (chunk < 2) ? 15 : (chunk < 4) ? 62 : 0;
      repeat (SAMPLES_PER_CHUNK) begin
        maybe_idle(idle_pct);
        send_word(draw_sample(), 1'b0, NO_REPORT);
      end
    end

    settle(100);
    $display("%0d samples taken: %0d closed a window, %0d dropped on a full table",
             samples_taken, reports_seen, drops_seen);
    $display("%0d register settings, sender gaps at 15%%, 62%% and none", settings_used);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/spt_pkg.sv
hw/rtl/spt_div.sv
hw/rtl/stage_profiler_table.sv
verif/stage_profiler_table_tb.sv
